// ----- design/bfpr_pkg.sv -----
package bfpr_pkg;

  // page geometry; byte_index is 6 bits, so a page holds at most 64 bytes
  localparam int PAGE_SIZE = 64;
  localparam int IDX_W     = 6;
  localparam int BYTE_W    = 8;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] PAD_BYTE   = 8'hFF;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROG_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROG_END    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_NUMBER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_DATA   = 3'd3;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_NONE = 2'd0;
  localparam status_t ST_DONE = 2'd1;
  localparam status_t ST_PAGE = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic [BYTE_W-1:0] expected_page;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic              signal_on;
    logic [BYTE_W-1:0] page_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] prog_start;
    logic [BYTE_W-1:0] prog_end;
    logic [BYTE_W-1:0] page_number;
    logic [BYTE_W-1:0] page_data;
  } cfg_t;

  // page buffer access: write enable, write address and data, read address
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

endpackage

// ----- design/bfpr_cfg_regs.sv -----
module bfpr_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bfpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfpr_pkg::BYTE_W-1:0]    cfg_wdata,
  output bfpr_pkg::cfg_t                 cfg
);
  import bfpr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prog_start  <= 8'd0;
      cfg.prog_end    <= 8'd1;
      cfg.page_number <= 8'd2;
      cfg.page_data   <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROG_START:  cfg.prog_start  <= cfg_wdata;
        CFG_PROG_END:    cfg.prog_end    <= cfg_wdata;
        CFG_PAGE_NUMBER: cfg.page_number <= cfg_wdata;
        CFG_PAGE_DATA:   cfg.page_data   <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// ----- design/bfpr_page_ram.sv -----
module bfpr_page_ram (
  input  logic                       clk,
  input  bfpr_pkg::ram_req_t         req,
  output logic [bfpr_pkg::BYTE_W-1:0] rd_data
);
  import bfpr_pkg::*;

  logic [BYTE_W-1:0] mem [PAGE_SIZE];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[req.raddr];
  end

endmodule

// ----- design/boot_frame_page_receiver_core.sv -----
// each byte's result sits in the output register in the cycle after its transaction, but
//   the closing byte of a valid page frame starts a run of PAGE_SIZE results instead
// throughput: one byte or run result per cycle while the output register is free; a run is
//   paced by the single buffer read port; no byte is taken until its last result is loaded
// reset: synchronous, active high; control state and registers but the result payload return
//   to reset values, the page buffer keeps its contents and needs no clearing pass
module boot_frame_page_receiver_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bfpr_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bfpr_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [bfpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfpr_pkg::BYTE_W-1:0]    cfg_wdata
);
  import bfpr_pkg::*;

  // frame parse phases plus the page delivery run
  typedef enum logic [7:0] {
    S_SOM1    = 8'b0000_0001,
    S_SOM2    = 8'b0000_0010,
    S_TYPE    = 8'b0000_0100,
    S_LEN     = 8'b0000_1000,
    S_DATA    = 8'b0001_0000,
    S_CRC1    = 8'b0010_0000,
    S_CRC2    = 8'b0100_0000,
    S_DELIVER = 8'b1000_0000
  } state_t;

  state_t            state, state_next;
  logic [BYTE_W-1:0] frame_type, frame_type_next;
  logic [BYTE_W-1:0] frame_length, frame_length_next;
  logic [BYTE_W-1:0] payload_count, payload_count_next;
  logic              pages_armed, pages_armed_next;
  logic [BYTE_W-1:0] upcoming_page, upcoming_page_next;
  logic              signal_level, signal_level_next;
  logic [IDX_W-1:0]  del_idx, del_idx_next;
  logic              out_valid_next;
  out_item_t         out_data_next;

  cfg_t              cfg;
  ram_req_t          ram_req;
  logic [BYTE_W-1:0] rd_data;

  logic              in_fire;
  logic              out_free;
  logic              err;
  logic              start_run;
  status_t           single_status;
  logic [BYTE_W-1:0] pc_inc;
  logic              del_last;
  logic              del_pad;

  bfpr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bfpr_page_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  // output register frees when empty or being taken this cycle
  assign out_free = !out_valid || out_ready;
  // no byte is taken while a page run is going out
  assign in_ready = (state != S_DELIVER) && out_free;
  assign in_fire  = in_valid && in_ready;

  assign pc_inc   = payload_count + 8'd1;
  assign del_last = (del_idx == IDX_W'(PAGE_SIZE - 1));
  // positions at or past the frame length are padded
  assign del_pad  = ({{(BYTE_W-IDX_W){1'b0}}, del_idx} >= frame_length);

  always_comb begin
    state_next         = state;
    frame_type_next    = frame_type;
    frame_length_next  = frame_length;
    payload_count_next = payload_count;
    pages_armed_next   = pages_armed;
    upcoming_page_next = upcoming_page;
    signal_level_next  = signal_level;
    del_idx_next       = del_idx;
    out_valid_next     = out_valid;
    out_data_next      = out_data;
    err                = 1'b0;
    start_run          = 1'b0;
    single_status      = ST_NONE;
    ram_req.we         = 1'b0;
    ram_req.waddr      = payload_count[IDX_W-1:0];
    ram_req.wdata      = in_data.rx_byte;

    // a taken result empties the output register unless refilled below
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    if (in_fire) begin
      unique case (state)
        S_SOM1: begin
          if (in_data.rx_byte == START_BYTE) begin
            state_next = S_SOM2;
          end else begin
            err = 1'b1;
          end
        end
        S_SOM2: begin
          if (in_data.rx_byte == START_BYTE) begin
            state_next = S_TYPE;
          end else begin
            err        = 1'b1;
            state_next = S_SOM1;
          end
        end
        S_TYPE: begin
          frame_type_next = in_data.rx_byte;
          state_next      = S_LEN;
        end
        S_LEN: begin
          frame_length_next  = in_data.rx_byte;
          payload_count_next = '0;
          state_next         = (in_data.rx_byte == '0) ? S_CRC1 : S_DATA;
        end
        S_DATA: begin
          // bytes beyond the page are dropped
          if (payload_count < BYTE_W'(PAGE_SIZE)) begin
            ram_req.we = 1'b1;
          end
          payload_count_next = pc_inc;
          if (pc_inc >= frame_length) begin
            state_next = S_CRC1;
          end
        end
        S_CRC1: begin
          state_next = S_CRC2;
        end
        S_CRC2: begin
          // frame complete: act on its type
          state_next = S_SOM1;
          if (frame_type == cfg.prog_start) begin
            signal_level_next = 1'b0;
            pages_armed_next  = 1'b1;
          end else if (frame_type == cfg.prog_end) begin
            pages_armed_next = 1'b0;
            single_status    = ST_DONE;
          end else if (pages_armed) begin
            if (frame_type == cfg.page_number) begin
              // buffer reads entry 0 while parsing, so rd_data holds payload byte 0
              upcoming_page_next = rd_data;
            end else if (frame_type == cfg.page_data) begin
              if ((frame_length > BYTE_W'(PAGE_SIZE)) ||
                  (upcoming_page != in_data.expected_page)) begin
                err = 1'b1;
              end else begin
                signal_level_next = 1'b0;
                start_run         = 1'b1;
                del_idx_next      = '0;
                state_next        = S_DELIVER;
              end
            end
          end
        end
        default: begin
          state_next = S_SOM1;
        end
      endcase

      // error handling only matters while pages are expected
      if (err && pages_armed) begin
        signal_level_next  = 1'b1;
        upcoming_page_next = '0;
      end

      if (!start_run) begin
        out_valid_next           = 1'b1;
        out_data_next.status     = single_status;
        out_data_next.signal_on  = signal_level_next;
        out_data_next.page_byte  = '0;
        out_data_next.byte_index = '0;
        out_data_next.last       = 1'b1;
      end
    end

    // page run: one buffer byte per free output slot, pad written back
    if ((state == S_DELIVER) && out_free) begin
      out_valid_next           = 1'b1;
      out_data_next.status     = ST_PAGE;
      out_data_next.signal_on  = signal_level;
      out_data_next.page_byte  = del_pad ? PAD_BYTE : rd_data;
      out_data_next.byte_index = del_idx;
      out_data_next.last       = del_last;
      if (del_pad) begin
        ram_req.we    = 1'b1;
        ram_req.waddr = del_idx;
        ram_req.wdata = PAD_BYTE;
      end
      if (del_last) begin
        state_next   = S_SOM1;
        del_idx_next = '0;
      end else begin
        del_idx_next = del_idx + IDX_W'(1);
      end
    end

    // read ahead for the run; otherwise keep entry 0 in the read register
    ram_req.raddr = (state_next == S_DELIVER) ? del_idx_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_SOM1;
      frame_type    <= '0;
      frame_length  <= '0;
      payload_count <= '0;
      pages_armed   <= 1'b0;
      upcoming_page <= '0;
      signal_level  <= 1'b1;
      del_idx       <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      frame_type    <= frame_type_next;
      frame_length  <= frame_length_next;
      payload_count <= payload_count_next;
      pages_armed   <= pages_armed_next;
      upcoming_page <= upcoming_page_next;
      signal_level  <= signal_level_next;
      del_idx       <= del_idx_next;
      out_valid     <= out_valid_next;
    end
  end

  // result payload carries no reset
  always_ff @(posedge clk) begin
    out_data <= out_data_next;
  end

endmodule

// ----- design/bfpr_checker.sv -----
module bfpr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input bfpr_pkg::out_item_t             out_data
);
  import bfpr_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // only page bytes may be non-final
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != ST_PAGE) |-> out_data.last)
    else $error("single result without last");

  // page bytes go out with the signal lowered and no byte taken mid run
  a_page_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_PAGE) && !out_data.last |->
      !out_data.signal_on && !in_ready)
    else $error("page run overlapped input or signal high");

  // a page run streams its bytes back to back in index order
  a_page_next: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && (out_data.status == ST_PAGE) && !out_data.last |=>
      out_valid && (out_data.status == ST_PAGE) &&
      (out_data.byte_index == IDX_W'($past(out_data.byte_index) + IDX_W'(1))))
    else $error("page run broke sequence");

endmodule

bind boot_frame_page_receiver_core bfpr_checker u_bfpr_checker (.*);
